FILE: src/bbs_pkg.sv
// Package for the bridge bring-up sequencer: state and command codes,
// field widths and shared types. No dependencies.
package bbs_pkg;

    localparam int DEF_NUM_BRIDGES = 4;
    localparam int MAX_SCANNED     = 4;   // only four bridges have wanted registers
    localparam int BR_W            = 2;
    localparam int CODE_W          = 3;
    localparam int CFG_IDX_W       = 3;
    localparam int IN_DATA_W       = 8;
    localparam int OUT_DATA_W      = 8;

    typedef enum logic [CODE_W-1:0] {
        ST_UNCFG    = 3'd0,
        ST_SENSORS  = 3'd1,
        ST_ACTUATOR = 3'd2,
        ST_CTRL     = 3'd3,
        ST_RUNNING  = 3'd4,
        ST_SENS_ERR = 3'd5,
        ST_ACT_ERR  = 3'd6,
        ST_UNKNOWN  = 3'd7
    } t_state_code;

    typedef enum logic [2:0] {
        CMD_CLR_SENS = 3'd0,
        CMD_CLR_ACT  = 3'd1,
        CMD_REQ      = 3'd2,
        CMD_UNCFG    = 3'd3,
        CMD_SENS_CFG = 3'd4,
        CMD_ACT_CFG  = 3'd5,
        CMD_CTRL_CFG = 3'd6,
        CMD_ZERO     = 3'd7
    } t_cmd;

    // one table entry as seen by the evaluation unit
    typedef struct packed {
        logic [CODE_W-1:0] wanted;
        logic [CODE_W-1:0] reported;
        logic              pending;
    } t_entry;

    // announcement write into the state table
    typedef struct packed {
        logic              en;
        logic [BR_W-1:0]   br;
        logic [CODE_W-1:0] code;
    } t_ann;

    // pending flag update from the scan
    typedef struct packed {
        logic en;
        logic value;
    } t_pend_upd;

    // decision for one bridge
    typedef struct packed {
        logic       act;        // bridge is visited (differs and not pending)
        logic       pend_next;
        logic [1:0] n_cmd;      // 0, 1 or 2 commands
        t_cmd       first;      // second command is always a state request
    } t_eval;

    // level: 0..4 normal, -1 error, -2 unknown
    function automatic logic signed [3:0] level_of(logic [CODE_W-1:0] code);
        logic signed [3:0] lv;
        case (code) inside
            [3'd0:3'd4]: lv = signed'({1'b0, code});
            3'd5, 3'd6:  lv = -4'sd1;
            default:     lv = -4'sd2;
        endcase
        return lv;
    endfunction

    function automatic logic raised_limit(t_cmd cmd, logic [BR_W-1:0] br);
        return (cmd == CMD_ACT_CFG) && !br[1];
    endfunction

endpackage

FILE: src/bbs_state.sv
// Per-bridge wanted, reported and pending registers with one scan read port.
// Depends on bbs_pkg.
module bbs_state #(
    parameter int NUM_BRIDGES = bbs_pkg::DEF_NUM_BRIDGES
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  bbs_pkg::t_ann                        i_ann,
    input  logic                                 i_cfg_we,
    input  logic [bbs_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [bbs_pkg::CODE_W-1:0]           i_cfg_data,
    input  logic [((NUM_BRIDGES < 4 ? NUM_BRIDGES : 4) > 1 ?
                   $clog2(NUM_BRIDGES < 4 ? NUM_BRIDGES : 4) : 1)-1:0] i_rd_idx,
    input  bbs_pkg::t_pend_upd                   i_pend_upd,
    output bbs_pkg::t_entry                      o_entry
);
    import bbs_pkg::*;

    localparam int SCAN_LIMIT = (NUM_BRIDGES < MAX_SCANNED) ? NUM_BRIDGES : MAX_SCANNED;
    localparam int IDX_W      = (SCAN_LIMIT > 1) ? $clog2(SCAN_LIMIT) : 1;

    logic [CODE_W-1:0] r_wanted   [SCAN_LIMIT];
    logic [CODE_W-1:0] r_reported [SCAN_LIMIT];
    logic              r_pending  [SCAN_LIMIT];

    logic ann_hit;
    logic cfg_hit;

    // bridges past the scanned range are never read, so they need no storage
    assign ann_hit = i_ann.en && ({1'b0, i_ann.br} < 3'(SCAN_LIMIT));
    assign cfg_hit = i_cfg_we && (i_cfg_index < CFG_IDX_W'(SCAN_LIMIT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SCAN_LIMIT; i++) begin
                r_wanted[i]   <= '0;
                r_reported[i] <= ST_UNCFG;
                r_pending[i]  <= 1'b0;
            end
        end else begin
            if (cfg_hit) begin
                r_wanted[i_cfg_index[IDX_W-1:0]] <= i_cfg_data;
            end
            if (ann_hit) begin
                r_reported[i_ann.br[IDX_W-1:0]] <= i_ann.code;
                r_pending[i_ann.br[IDX_W-1:0]]  <= 1'b0;
            end else if (i_pend_upd.en) begin
                r_pending[i_rd_idx] <= i_pend_upd.value;
            end
        end
    end

    assign o_entry.wanted   = r_wanted[i_rd_idx];
    assign o_entry.reported = r_reported[i_rd_idx];
    assign o_entry.pending  = r_pending[i_rd_idx];

endmodule

FILE: src/bbs_eval.sv
// Shared evaluation unit: level compare for the bridge under scan and the
// commands it needs. Depends on bbs_pkg.
module bbs_eval (
    input  bbs_pkg::t_entry i_entry,
    output bbs_pkg::t_eval  o_eval
);
    import bbs_pkg::*;

    logic signed [3:0] w_lv;
    logic signed [3:0] c_lv;
    logic [3:0]        c_plus;

    assign w_lv   = level_of(i_entry.wanted);
    assign c_lv   = level_of(i_entry.reported);
    assign c_plus = 4'(c_lv) + 4'd4;

    always_comb begin
        o_eval.act       = (i_entry.wanted != i_entry.reported) && !i_entry.pending;
        o_eval.pend_next = 1'b1;
        o_eval.n_cmd     = 2'd0;
        o_eval.first     = CMD_REQ;
        if (c_lv < 0) begin
            if (w_lv != 0) begin
                o_eval.pend_next = 1'b0;
            end else if (i_entry.reported == ST_SENS_ERR) begin
                o_eval.n_cmd = 2'd2;
                o_eval.first = CMD_CLR_SENS;
            end else if (i_entry.reported == ST_ACT_ERR) begin
                o_eval.n_cmd = 2'd2;
                o_eval.first = CMD_CLR_ACT;
            end
            // unknown with wanted level zero: stays pending, silent
        end else if (w_lv < c_lv) begin
            o_eval.n_cmd = 2'd1;
            o_eval.first = CMD_UNCFG;
        end else if (w_lv > c_lv) begin
            o_eval.n_cmd = 2'd1;
            o_eval.first = t_cmd'(c_plus[2:0]);
        end
    end

endmodule

FILE: src/bridge_bringup_sequencer_core.sv
// Bridge bring-up sequencer top level: scan sequencer, hold slot and output
// register. Depends on bbs_pkg, bbs_state and bbs_eval.
//
// Usage:
//   Slave stream: tuser is the item kind (0 scan tick, 1 state announcement),
//   tdata carries bridge index and announced state code.
//   Master stream: one word per command; tlast marks the final command of a
//   scan tick. A tick that causes no command produces no word.
//   Config channel: index 0..3 selects wanted_state_0..3; always ready.
//   A scan tick visits the bridges one per cycle through the shared
//   evaluation unit while the output side keeps up; a bridge that needs a
//   second command is visited again for it, and a flush state passes the
//   last command on. The input is not ready while a scan runs. One command
//   is held back so tlast can be set on the final one; a found word passes
//   the hold slot and then the output register before it shows on the
//   master side. A receiver stall halts the scan once the hold slot and the
//   output register are both full; nothing is lost.
//   Synchronous reset clears the state table (unconfigured, not pending),
//   the wanted registers and all valid flags.
module bridge_bringup_sequencer_core #(
    parameter int NUM_BRIDGES = bbs_pkg::DEF_NUM_BRIDGES
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // slave stream
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [bbs_pkg::IN_DATA_W-1:0]        i_s_tdata,  // [1:0] bridge, [4:2] state_code
    input  logic                                 i_s_tuser,  // [0] kind
    // master stream
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [1:0] target_bridge, [4:2] command, [5] raised_current_limit
    output logic [bbs_pkg::OUT_DATA_W-1:0]       o_m_tdata,
    output logic                                 o_m_tlast,
    // config write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bbs_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [bbs_pkg::CODE_W-1:0]           i_cfg_data
);
    import bbs_pkg::*;

    localparam int SCAN_LIMIT = (NUM_BRIDGES < MAX_SCANNED) ? NUM_BRIDGES : MAX_SCANNED;
    localparam int IDX_W      = (SCAN_LIMIT > 1) ? $clog2(SCAN_LIMIT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SCAN_LIMIT - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } t_seq_state;

    t_seq_state        r_state;
    logic [IDX_W-1:0]  r_idx;
    logic              r_sub;        // second command of the current bridge
    logic              r_hold_valid;
    logic [BR_W-1:0]   r_hold_br;
    t_cmd              r_hold_cmd;
    logic              r_out_valid;
    logic [BR_W-1:0]   r_out_br;
    t_cmd              r_out_cmd;
    logic              r_out_last;

    t_entry    entry;
    t_eval     ev;
    t_ann      ann;
    t_pend_upd pend_upd;

    logic      in_acc;
    logic      out_free;
    logic      cur_has;
    t_cmd      cur_cmd;
    logic      can_go;
    logic      out_load;
    logic [BR_W-1:0] cur_br;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_s_tvalid && o_s_tready;
    assign out_free    = !r_out_valid || i_m_tready;

    assign ann.en   = in_acc && i_s_tuser;
    assign ann.br   = i_s_tdata[BR_W-1:0];
    assign ann.code = i_s_tdata[BR_W+CODE_W-1:BR_W];

    assign cur_has = r_sub || (ev.act && (ev.n_cmd != 2'd0));
    assign cur_cmd = r_sub ? CMD_REQ : ev.first;
    assign can_go  = !cur_has || !r_hold_valid || out_free;
    assign cur_br  = BR_W'(r_idx);

    // held word moves to the output register
    assign out_load = ((r_state == S_SCAN) && can_go && cur_has && r_hold_valid) ||
                      ((r_state == S_FLUSH) && r_hold_valid && out_free);

    assign pend_upd.en    = (r_state == S_SCAN) && can_go && !r_sub && ev.act;
    assign pend_upd.value = ev.pend_next;

    bbs_state #(
        .NUM_BRIDGES (NUM_BRIDGES)
    ) u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ann       (ann),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rd_idx    (r_idx),
        .i_pend_upd  (pend_upd),
        .o_entry     (entry)
    );

    bbs_eval u_eval (
        .i_entry (entry),
        .o_eval  (ev)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_sub        <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && !i_s_tuser) begin
                        r_state <= S_SCAN;
                        r_idx   <= '0;
                        r_sub   <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (can_go) begin
                        if (cur_has) begin
                            if (r_hold_valid) begin
                                r_out_br    <= r_hold_br;
                                r_out_cmd   <= r_hold_cmd;
                                r_out_last  <= 1'b0;
                            end
                            r_hold_valid <= 1'b1;
                            r_hold_br    <= cur_br;
                            r_hold_cmd   <= cur_cmd;
                        end
                        if (!r_sub && ev.act && (ev.n_cmd == 2'd2)) begin
                            r_sub <= 1'b1;
                        end else begin
                            r_sub <= 1'b0;
                            if (r_idx == LAST_IDX) begin
                                r_state <= S_FLUSH;
                            end else begin
                                r_idx <= r_idx + 1'b1;
                            end
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_hold_valid) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out_br     <= r_hold_br;
                        r_out_cmd    <= r_hold_cmd;
                        r_out_last   <= 1'b1;
                        r_hold_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, raised_limit(r_out_cmd, r_out_br), r_out_cmd, r_out_br};
    assign o_m_tlast  = r_out_last;

endmodule

FILE: src/bbs_checker.sv
// Port-level checks for the bridge bring-up sequencer, bound to the top level.
// Depends on bbs_pkg and bridge_bringup_sequencer_core.
module bbs_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic                           i_s_tuser,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [bbs_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic                           o_m_tlast
);
    import bbs_pkg::*;

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output word changed while stalled");

    // raised limit only on actuator config for bridge 0 or 1
    a_raised: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[5] |-> (o_m_tdata[4:2] == CMD_ACT_CFG) && !o_m_tdata[1])
        else $error("raised current limit on wrong command");

    // an announcement leaves the block ready
    a_ann_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser |=> o_s_tready)
        else $error("not ready after announcement");

    // a scan tick occupies the block
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !i_s_tuser |=> !o_s_tready)
        else $error("ready right after scan tick");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind bridge_bringup_sequencer_core bbs_checker u_bbs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

FILE: tb/bridge_bringup_sequencer_core_tb.sv
// Self-checking testbench for bridge_bringup_sequencer_core: directed table, then random
// announcements and scan ticks checked word by word against a behavioral predictor.
// Depends on bbs_pkg and the bridge_bringup_sequencer_core RTL.
module bridge_bringup_sequencer_core_tb;
    import bbs_pkg::*;

    localparam bit KIND_TICK = 1'b0;
    localparam bit KIND_ANN  = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_WANTED_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WANTED_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WANTED_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WANTED_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 3'd5;   // no register behind it
    localparam int RAISED_BRIDGES = 2;      // bridges 0 and 1 use the higher current limit
    localparam int PREDICTED      = -1;     // table row checked by the predictor
    localparam int QUIET_CYCLES   = 16;     // room for a full scan with flush
    localparam int ITEMS_PER_SET  = 68;
    localparam int PRESSURE_EVERY = 36;
    localparam int CYCLE_LIMIT    = 400000;

    typedef struct packed {
        logic [BR_W-1:0] br;
        t_cmd            cmd;
        logic            raised;
        logic            last;
    } cmd_word_t;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_op_e;

    typedef struct packed {
        row_op_e                op;
        logic                   kind;
        logic [BR_W-1:0]        br;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CODE_W-1:0]      val;
        int                     n_typed;
        cmd_word_t [3:0]        exp;
    } dir_row_t;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata   = '0;
    logic                  i_s_tuser   = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tlast;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CODE_W-1:0]     i_cfg_data  = '0;

    // predictor state
    t_state_code want_st [MAX_SCANNED];
    t_state_code rep_st  [MAX_SCANNED];
    logic        pend_st [MAX_SCANNED];
    cmd_word_t   cmd_exp_q[$];
    cmd_word_t   oldest_cmd;

    int tx_idle_pct = 27;
    int rx_idle_pct = 74;
    int n_err   = 0;
    int n_items = 0;
    int n_ticks = 0;
    int n_words = 0;
    int n_cfg   = 0;
    int cycle_cnt = 0;

    bridge_bringup_sequencer_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("** bridge_bringup_sequencer_core: FAILED **");
            $finish;
        end
    end

    // level: 0..4 normal, -1 either error, -2 unknown
    function automatic int bring_level(t_state_code code);
        if (code <= ST_RUNNING) return int'(code);
        if (code == ST_UNKNOWN) return -2;
        return -1;
    endfunction

    function automatic cmd_word_t mk_word(int br, t_cmd cmd, logic raised, logic last);
        cmd_word_t w;
        w.br     = BR_W'(br);
        w.cmd    = cmd;
        w.raised = raised;
        w.last   = last;
        return w;
    endfunction

    function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, t_state_code val);
        dir_row_t r;
        r = '0;
        r.op  = ROW_CFG;
        r.idx = idx;
        r.val = val;
        return r;
    endfunction

    function automatic dir_row_t item_row(logic kind, int br, t_state_code code, int n,
                                          cmd_word_t e0 = '0, cmd_word_t e1 = '0,
                                          cmd_word_t e2 = '0, cmd_word_t e3 = '0);
        dir_row_t r;
        r = '0;
        r.op      = ROW_ITEM;
        r.kind    = kind;
        r.br      = BR_W'(br);
        r.val     = code;
        r.n_typed = n;
        r.exp     = {e3, e2, e1, e0};
        return r;
    endfunction

    // Updates the bridge table for one word; on a scan tick the commands it
    // causes go to the expectation queue when record is set.
    task automatic predict_commands(input logic kind, input logic [BR_W-1:0] br,
                                    input logic [CODE_W-1:0] code, input bit record);
        cmd_word_t found[$];
        t_cmd      cfg_cmd;
        int        w;
        int        c;
        if (kind == KIND_ANN) begin
            rep_st[br]  = t_state_code'(code);
            pend_st[br] = 1'b0;
        end else begin
            for (int i = 0; i < MAX_SCANNED; i++) begin
                if (want_st[i] == rep_st[i] || pend_st[i]) continue;
                pend_st[i] = 1'b1;
                w = bring_level(want_st[i]);
                c = bring_level(rep_st[i]);
                if (c < 0) begin
                    // error or unknown: only a wanted unconfigured level recovers it
                    if (w != 0) begin
                        pend_st[i] = 1'b0;
                    end else if (rep_st[i] == ST_SENS_ERR) begin
                        found.push_back(mk_word(i, CMD_CLR_SENS, 1'b0, 1'b0));
                        found.push_back(mk_word(i, CMD_REQ, 1'b0, 1'b0));
                    end else if (rep_st[i] == ST_ACT_ERR) begin
                        found.push_back(mk_word(i, CMD_CLR_ACT, 1'b0, 1'b0));
                        found.push_back(mk_word(i, CMD_REQ, 1'b0, 1'b0));
                    end
                end else if (w < c) begin
                    found.push_back(mk_word(i, CMD_UNCFG, 1'b0, 1'b0));
                end else if (w > c) begin
                    // step to level c+1
                    cfg_cmd = t_cmd'(CMD_SENS_CFG + c);
                    found.push_back(mk_word(i, cfg_cmd,
                        cfg_cmd == CMD_ACT_CFG && i < RAISED_BRIDGES, 1'b0));
                end
            end
            if (found.size() != 0) found[found.size()-1].last = 1'b1;
            if (record) foreach (found[k]) cmd_exp_q.push_back(found[k]);
        end
    endtask

    task automatic send_word(input logic kind, input logic [BR_W-1:0] br,
                             input logic [CODE_W-1:0] code, input bit record);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {3'b000, code, br};
        do @(posedge i_clk); while (!o_s_tready);
        predict_commands(kind, br, code, record);
        n_items++;
        if (kind == KIND_TICK) n_ticks++;
    endtask

    // hold the input until every expected command has left, then let a
    // command-free scan finish
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (cmd_exp_q.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CODE_W-1:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx < MAX_SCANNED) want_st[idx[BR_W-1:0]] = t_state_code'(val);
        n_cfg++;
        @(posedge i_clk);
    endtask

    // output side: check against the oldest expectation, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            n_words++;
            if (cmd_exp_q.size() == 0) begin
                $error("unexpected command word: tdata=%h tlast=%b", o_m_tdata, o_m_tlast);
                n_err++;
            end else begin
                oldest_cmd = cmd_exp_q.pop_front();
                if (o_m_tdata[1:0] !== oldest_cmd.br) begin
                    $error("target_bridge: expected %0d, got %0d",
                           oldest_cmd.br, o_m_tdata[1:0]);
                    n_err++;
                end
                if (o_m_tdata[4:2] !== oldest_cmd.cmd) begin
                    $error("command: expected %0d, got %0d", oldest_cmd.cmd, o_m_tdata[4:2]);
                    n_err++;
                end
                if (o_m_tdata[5] !== oldest_cmd.raised) begin
                    $error("raised_current_limit: expected %0b, got %0b",
                           oldest_cmd.raised, o_m_tdata[5]);
                    n_err++;
                end
                if (o_m_tlast !== oldest_cmd.last) begin
                    $error("last: expected %0b, got %0b", oldest_cmd.last, o_m_tlast);
                    n_err++;
                end
            end
        end
        i_m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    initial begin
        dir_row_t    dir_tab[$];
        dir_row_t    row;
        t_state_code want_plan [6][MAX_SCANNED];
        bit          plan_rand [6] = '{0, 0, 1, 0, 1, 0};
        int          tx_plan [3] = '{27, 74, 0};
        int          rx_plan [3] = '{74, 27, 0};
        logic [BR_W-1:0]   br;
        logic [CODE_W-1:0] code;
        int          pick;

        for (int i = 0; i < MAX_SCANNED; i++) begin
            want_st[i] = ST_UNCFG;
            rep_st[i]  = ST_UNCFG;
            pend_st[i] = 1'b0;
        end
        want_plan[0] = '{ST_RUNNING, ST_RUNNING, ST_RUNNING, ST_RUNNING};
        want_plan[1] = '{ST_UNCFG, ST_CTRL, ST_UNKNOWN, ST_ACT_ERR};
        want_plan[2] = '{ST_UNCFG, ST_UNCFG, ST_UNCFG, ST_UNCFG};
        want_plan[3] = '{ST_SENS_ERR, ST_RUNNING, ST_ACTUATOR, ST_SENSORS};
        want_plan[4] = '{ST_UNCFG, ST_UNCFG, ST_UNCFG, ST_UNCFG};
        want_plan[5] = '{ST_UNKNOWN, ST_UNCFG, ST_RUNNING, ST_ACT_ERR};

        // after reset everything matches: a tick sends nothing
        dir_tab.push_back(item_row(KIND_TICK, 0, ST_UNCFG, 0));
        dir_tab.push_back(cfg_row(REG_WANTED_0, ST_RUNNING));
        dir_tab.push_back(cfg_row(REG_WANTED_1, ST_ACTUATOR));
        dir_tab.push_back(cfg_row(REG_WANTED_2, ST_UNKNOWN));
        dir_tab.push_back(cfg_row(REG_WANTED_3, ST_SENS_ERR));
        // wanted error/unknown codes below a normal level give set unconfigured
        dir_tab.push_back(item_row(KIND_TICK, 3, ST_UNKNOWN, 4,
            mk_word(0, CMD_SENS_CFG, 1'b0, 1'b0), mk_word(1, CMD_SENS_CFG, 1'b0, 1'b0),
            mk_word(2, CMD_UNCFG, 1'b0, 1'b0), mk_word(3, CMD_UNCFG, 1'b0, 1'b1)));
        dir_tab.push_back(item_row(KIND_TICK, 0, ST_UNCFG, 0));        // all pending
        dir_tab.push_back(item_row(KIND_ANN, 0, ST_SENSORS, 0));
        dir_tab.push_back(item_row(KIND_ANN, 1, ST_ACTUATOR, 0));
        dir_tab.push_back(item_row(KIND_TICK, 0, ST_UNCFG, 1,
            mk_word(0, CMD_ACT_CFG, 1'b1, 1'b1)));
        dir_tab.push_back(item_row(KIND_ANN, 0, ST_ACTUATOR, 0));
        dir_tab.push_back(item_row(KIND_TICK, 0, ST_UNCFG, 1,
            mk_word(0, CMD_CTRL_CFG, 1'b0, 1'b1)));
        dir_tab.push_back(item_row(KIND_ANN, 0, ST_CTRL, 0));
        dir_tab.push_back(item_row(KIND_TICK, 2, ST_RUNNING, 1,
            mk_word(0, CMD_ZERO, 1'b0, 1'b1)));
        dir_tab.push_back(item_row(KIND_ANN, 0, ST_RUNNING, 0));
        // sensor error while a non-zero level is wanted: pending dropped, no command
        dir_tab.push_back(item_row(KIND_ANN, 2, ST_SENS_ERR, 0));
        dir_tab.push_back(item_row(KIND_TICK, 0, ST_UNCFG, 0));
        dir_tab.push_back(cfg_row(REG_WANTED_1, ST_SENSORS));
        dir_tab.push_back(cfg_row(REG_WANTED_2, ST_UNCFG));
        dir_tab.push_back(cfg_row(REG_WANTED_3, ST_UNCFG));
        dir_tab.push_back(cfg_row(REG_SPARE, ST_UNKNOWN));              // ignored write
        dir_tab.push_back(item_row(KIND_ANN, 3, ST_ACT_ERR, 0));
        // step down plus both error clears, five words in one tick
        dir_tab.push_back(item_row(KIND_TICK, 1, ST_SENSORS, PREDICTED));
        dir_tab.push_back(item_row(KIND_ANN, 2, ST_UNKNOWN, 0));
        dir_tab.push_back(item_row(KIND_ANN, 3, ST_UNKNOWN, 0));
        // unknown with level 0 wanted stays pending, silent
        dir_tab.push_back(item_row(KIND_TICK, 3, ST_ACT_ERR, 0));
        dir_tab.push_back(item_row(KIND_ANN, 1, ST_ACT_ERR, 0));
        dir_tab.push_back(item_row(KIND_TICK, 0, ST_UNCFG, 0));
        dir_tab.push_back(cfg_row(REG_WANTED_3, ST_ACTUATOR));
        dir_tab.push_back(item_row(KIND_ANN, 3, ST_SENSORS, 0));
        // actuator config on bridge 3 keeps the normal limit
        dir_tab.push_back(item_row(KIND_TICK, 0, ST_UNCFG, 1,
            mk_word(3, CMD_ACT_CFG, 1'b0, 1'b1)));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[r]) begin
            row = dir_tab[r];
            if (row.op == ROW_CFG) begin
                write_reg(row.idx, row.val);
            end else begin
                send_word(row.kind, row.br, row.val, row.n_typed == PREDICTED);
                for (int e = 0; e < row.n_typed; e++) cmd_exp_q.push_back(row.exp[e]);
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = tx_plan[ph];
            rx_idle_pct = rx_plan[ph];
            for (int s = 0; s < 2; s++) begin
                for (int r = 0; r < MAX_SCANNED; r++) begin
                    if (plan_rand[ph*2+s])
                        code = ($urandom_range(0, 9) < 8) ? CODE_W'($urandom_range(0, 4))
                                                          : CODE_W'($urandom_range(5, 7));
                    else
                        code = want_plan[ph*2+s][r];
                    write_reg(CFG_IDX_W'(r), code);
                end
                write_reg(CFG_IDX_W'($urandom_range(MAX_SCANNED, 7)),
                          CODE_W'($urandom_range(0, 7)));

                for (int k = 0; k < ITEMS_PER_SET; k++) begin
                    if (k != 0 && k % PRESSURE_EVERY == 0) drain();
                    br   = BR_W'($urandom_range(0, 3));
                    pick = $urandom_range(0, 99);
                    if (pick < 35) begin
                        send_word(KIND_TICK, br, CODE_W'($urandom_range(0, 7)), 1'b1);
                    end else begin
                        // mostly announce what the bridge would report after the
                        // last command, so the scan climbs through the levels
                        if (pick < 55)
                            code = CODE_W'($urandom_range(0, 7));
                        else if (rep_st[br] >= ST_SENS_ERR ||
                                 bring_level(want_st[br]) < bring_level(rep_st[br]))
                            code = ST_UNCFG;
                        else if (bring_level(want_st[br]) > bring_level(rep_st[br]))
                            code = rep_st[br] + 1'b1;
                        else
                            code = want_st[br];
                        send_word(KIND_ANN, br, code, 1'b1);
                    end
                end
            end
        end

        drain();
        $display("Ran %0d words in (%0d scan ticks), %0d register writes, %0d commands checked",
                 n_items, n_ticks, n_cfg, n_words);
        $display("over three handshake pressure phases and six wanted-state settings.");
        if (n_err == 0 && cmd_exp_q.size() == 0) begin
            $display("** bridge_bringup_sequencer_core: PASSED **");
        end else begin
            $display("** bridge_bringup_sequencer_core: FAILED **");
        end
        $finish;
    end

endmodule

FILE: bridge_bringup_sequencer_core.f
src/bbs_pkg.sv
src/bbs_state.sv
src/bbs_eval.sv
src/bridge_bringup_sequencer_core.sv
src/bbs_checker.sv
tb/bridge_bringup_sequencer_core_tb.sv
